[hdl/pitch_scale_quantizer_unit_macros.svh]
// ---------------------------------------------------------------------------
// pitch_scale_quantizer_unit_macros.svh
// Assertion shorthands shared by the quantiser modules. Every module that
// uses them has ports named aclk and aresetn.
// ---------------------------------------------------------------------------
`ifndef PITCH_SCALE_QUANTIZER_UNIT_MACROS_SVH
`define PITCH_SCALE_QUANTIZER_UNIT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define PSQ_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define PSQ_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/psq_pkg.sv]
// ---------------------------------------------------------------------------
// psq_pkg
// Widths, constants and shared types of the pitch scale quantiser.
// ---------------------------------------------------------------------------
package psq_pkg;

    localparam int NoteW     = 16;   // Q8.8 input pitch
    localparam int OutW      = 17;   // Q9.8 snapped pitch
    localparam int CandW     = 9;    // integer candidate note, signed
    localparam int DistW     = 17;   // absolute Q9.8 distance
    localparam int ClsW      = 4;    // pitch class 0..11
    localparam int MaskW     = 12;
    localparam int RootW     = 4;
    localparam int FracW     = 8;

    localparam int Semis     = 12;
    localparam int NumCells  = 2 * Semis + 1;
    // Multiple of twelve that keeps (centre - root) non-negative.
    localparam int ClsOffset = 12 * Semis;
    // floor(v / 12) == (v * 171) >> 11 for every v below 300.
    localparam int RecipMul   = 171;
    localparam int RecipShift = 11;

    typedef enum logic {
        REG_KEY_SET   = 1'b0,
        REG_ROOT_NOTE = 1'b1
    } psq_reg_t;

    typedef struct packed {
        logic [MaskW-1:0] key_set;
        logic [RootW-1:0] root_note;
    } psq_cfg_t;

    // Token handed from cell to cell along the chain.
    typedef struct packed {
        logic                    valid;
        logic signed [NoteW-1:0] x;
        logic signed [CandW-1:0] cand;
        logic [ClsW-1:0]         cls;
        logic signed [CandW-1:0] best;
        logic [DistW-1:0]        gap;
        logic                    found;
    } psq_tok_t;

endpackage

[hdl/psq_front.sv]
// ---------------------------------------------------------------------------
// psq_front
// Rounds the input pitch to the nearest note and works out the pitch class
// of the lowest candidate, over two registered stages.
// ---------------------------------------------------------------------------
`include "pitch_scale_quantizer_unit_macros.svh"

module psq_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            advance,
    input  logic                            in_valid,
    input  logic signed [psq_pkg::NoteW-1:0] in_note,
    input  psq_pkg::psq_cfg_t               cfg,
    output psq_pkg::psq_tok_t               tok_o
);
    import psq_pkg::*;

    logic                    s1_valid_reg;
    logic signed [NoteW-1:0] s1_x_reg;
    logic signed [CandW-1:0] s1_center_reg;
    logic signed [CandW-1:0] center_next;
    logic [NoteW:0]          round_sum;

    logic [RootW-1:0]        root_red;
    logic [CandW:0]          offset_val;
    logic [CandW-1:0]        pos_val;
    logic [16:0]             recip_prod;
    logic [5:0]              quot;
    logic [CandW-1:0]        quot_x12;
    logic [CandW-1:0]        rem_val;
    psq_tok_t                tok_next;
    psq_tok_t                tok_reg;

    // Halves go away from zero: add 128 for positive, 127 for negative,
    // then floor by an arithmetic shift.
    always_comb begin
        round_sum   = {in_note[NoteW-1], in_note}
                    + (in_note[NoteW-1] ? 17'd127 : 17'd128);
        center_next = round_sum[NoteW:FracW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= in_valid;
        end
        if (advance) begin
            s1_x_reg      <= in_note;
            s1_center_reg <= center_next;
        end
    end

    // Class of (centre - root) modulo twelve by reciprocal multiplication.
    always_comb begin
        root_red   = (cfg.root_note >= RootW'(Semis)) ? cfg.root_note - RootW'(Semis)
                                                      : cfg.root_note;
        offset_val = {s1_center_reg[CandW-1], s1_center_reg} + (CandW+1)'(ClsOffset)
                   - {6'd0, root_red};
        pos_val    = offset_val[CandW-1:0];
        recip_prod = 17'(pos_val) * 17'(RecipMul);
        quot       = recip_prod[16:RecipShift];
        quot_x12   = CandW'(quot) * CandW'(Semis);
        rem_val    = pos_val - quot_x12;

        tok_next       = '0;
        tok_next.valid = s1_valid_reg;
        tok_next.x     = s1_x_reg;
        tok_next.cand  = s1_center_reg - CandW'(Semis);
        tok_next.cls   = rem_val[ClsW-1:0];
        tok_next.best  = '0;
        tok_next.gap   = '0;
        tok_next.found = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else if (advance) begin
            tok_reg <= tok_next;
        end
    end

    assign tok_o = tok_reg;

    `PSQ_ASSERT_IMP(a_front_cls_range, tok_reg.valid, tok_reg.cls < ClsW'(Semis), "front produced a pitch class above eleven")
    `PSQ_ASSERT_NXT(a_front_cand_start, advance && s1_valid_reg, tok_reg.valid && (tok_reg.cand == $past(s1_center_reg) - CandW'(Semis)), "first candidate is not twelve below the rounded note")
    `PSQ_ASSERT_IMP(a_front_clean_start, tok_reg.valid, !tok_reg.found, "token leaves the front with a match already set")

endmodule

[hdl/psq_cell.sv]
// ---------------------------------------------------------------------------
// psq_cell
// One link of the candidate chain: tests one candidate note against the
// scale, keeps the nearer of it and the best so far, and passes on the next.
// ---------------------------------------------------------------------------
`include "pitch_scale_quantizer_unit_macros.svh"

module psq_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic [psq_pkg::MaskW-1:0]   key_set,
    input  psq_pkg::psq_tok_t           tok_i,
    output psq_pkg::psq_tok_t           tok_o
);
    import psq_pkg::*;

    logic signed [DistW:0] pos_x;
    logic signed [DistW:0] pos_c;
    logic signed [DistW:0] diff;
    logic signed [DistW:0] neg_diff;
    logic [DistW-1:0]      cand_gap;
    logic                  allowed;
    logic                  take;
    psq_tok_t              tok_next;
    psq_tok_t              tok_reg;

    always_comb begin
        pos_x    = {{2{tok_i.x[NoteW-1]}}, tok_i.x};
        pos_c    = {tok_i.cand[CandW-1], tok_i.cand, {FracW{1'b0}}};
        diff     = pos_x - pos_c;
        neg_diff = -diff;
        cand_gap = diff[DistW] ? neg_diff[DistW-1:0] : diff[DistW-1:0];
        allowed  = key_set[tok_i.cls];
        // Strict compare: an equal distance keeps the lower, earlier note.
        take     = allowed && (!tok_i.found || (cand_gap < tok_i.gap));

        tok_next      = tok_i;
        tok_next.cand = tok_i.cand + CandW'(1);
        tok_next.cls  = (tok_i.cls == ClsW'(Semis - 1)) ? '0 : tok_i.cls + ClsW'(1);
        if (take) begin
            tok_next.best  = tok_i.cand;
            tok_next.gap   = cand_gap;
            tok_next.found = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else if (advance) begin
            tok_reg <= tok_next;
        end
    end

    assign tok_o = tok_reg;

    `PSQ_ASSERT_IMP(a_cell_cls_range, tok_reg.valid, tok_reg.cls < ClsW'(Semis), "pitch class left its range in the chain")
    `PSQ_ASSERT_NXT(a_cell_found_kept, advance && tok_i.valid && tok_i.found, tok_reg.found && (tok_reg.gap <= $past(tok_i.gap)), "cell lost or worsened an earlier match")
    `PSQ_ASSERT_NXT(a_cell_cand_step, advance && tok_i.valid, tok_reg.cand == $past(tok_i.cand) + CandW'(1), "candidate did not step by one semitone")

endmodule

[hdl/pitch_scale_quantizer_unit.sv]
// ---------------------------------------------------------------------------
// pitch_scale_quantizer_unit
// Snaps a Q8.8 note number to the nearest note of a rotated 12-note scale.
//
//   Channel   Dir  Width  Contents
//   s_axis    in   16     note_in, signed Q8.8
//   m_axis    out  24     note_out, signed Q9.8, in bits 16:0
//   apb       in   32     allowed pitch classes at 0x0, root_note at 0x4
//
// One word is taken every cycle unless the output stalls. A word passes
// 28 registers: two front stages, one cell for each of the 25 candidates,
// and the output register. The first is loaded at the accepting edge; the
// length of the cell chain sets the latency.
// Reset is synchronous and active low; it empties the pipeline and sets a
// chromatic scale with root zero.
// When m_tready is low with a result waiting, the whole chain holds and
// s_tready drops in the same cycle.
// ---------------------------------------------------------------------------
`include "pitch_scale_quantizer_unit_macros.svh"

module pitch_scale_quantizer_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] note_in

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [16:0] note_out, [23:17] zero

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import psq_pkg::*;

    // Configuration registers. Only paddr[2] selects a register, so every
    // write lands in one of the two.
    logic [MaskW-1:0] key_set_reg;
    logic [RootW-1:0] root_note_reg;
    psq_cfg_t         cfg;
    psq_reg_t         reg_sel;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = psq_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_set_reg   <= {MaskW{1'b1}};
            root_note_reg <= '0;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_KEY_SET:   key_set_reg   <= pwdata[MaskW-1:0];
                REG_ROOT_NOTE: root_note_reg <= pwdata[RootW-1:0];
                default:       key_set_reg   <= key_set_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_KEY_SET:   prdata = {20'd0, key_set_reg};
            REG_ROOT_NOTE: prdata = {28'd0, root_note_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.key_set   = key_set_reg;
    assign cfg.root_note = root_note_reg;

    // The whole pipeline moves together whenever the output register is
    // free or being emptied in this cycle.
    logic advance;
    logic m_tvalid_reg;
    logic [23:0] m_tdata_reg;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;

    psq_tok_t tok [NumCells+1];

    psq_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .in_valid (s_tvalid),
        .in_note  (s_tdata),
        .cfg      (cfg),
        .tok_o    (tok[0])
    );

    // Chain of candidate cells, lowest candidate first, so that a tie is
    // won by the note met first.
    for (genvar i = 0; i < NumCells; i++) begin : g_cell
        psq_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .key_set  (cfg.key_set),
            .tok_i    (tok[i]),
            .tok_o    (tok[i+1])
        );
    end

    // An empty mask passes the input straight through, sign-extended.
    logic [OutW-1:0] note_out_next;

    always_comb begin
        if (cfg.key_set == '0) begin
            note_out_next = {tok[NumCells].x[NoteW-1], tok[NumCells].x};
        end else begin
            note_out_next = {tok[NumCells].best, {FracW{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= tok[NumCells].valid;
        end
        if (advance) begin
            m_tdata_reg <= {7'd0, note_out_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `PSQ_ASSERT_IMP(a_snap_integer, m_tvalid && (cfg.key_set != '0), m_tdata[FracW-1:0] == '0, "snapped note carries a fraction")
    `PSQ_ASSERT_IMP(a_found_at_end, tok[NumCells].valid && (cfg.key_set != '0), tok[NumCells].found, "no scale note found among the candidates")
    `PSQ_ASSERT_IMP(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready, "input taken while the output is stalled")

endmodule
